// ===== sv/swm_pkg.sv =====
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int                      WINDOW_LEN_W     = 7;
    localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 7'd3;

    // Controls broadcast to every candidate cell for one transfer.
    typedef struct packed {
        logic accept;
        logic first;
        logic retire;
        logic full;
    } swm_ctrl_t;

endpackage

// ===== sv/swm_cell.sv =====
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           prev_keep,
    input  logic                           next_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] next_value,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           keep
);
    import swm_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;
    logic                           shifted_valid;
    logic signed [SAMPLE_WIDTH-1:0] shifted_value;

    always_comb begin
        shifted_valid = ctrl.first ? 1'b0 : (ctrl.retire ? next_valid : valid_reg);
        shifted_value = ctrl.retire ? next_value : value_reg;
        keep          = shifted_valid && !(shifted_value < sample);

        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.accept) begin
            if (ctrl.full) begin
                // The queue is full of kept candidates: the oldest one goes.
                valid_next = 1'b1;
                value_next = next_value;
            end else begin
                valid_next = keep || prev_keep;
                value_next = keep ? shifted_value : sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// ===== sv/swm_history.sv =====
module swm_history #(
    parameter int DEPTH        = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH   = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int ADDR_W       = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);
    import swm_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the slot being written returns the new sample.
    always_ff @(posedge aclk) begin
        if (wr_en && (rd_addr == wr_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sliding_window_maximum.sv =====
// Sliding-window maximum of a stream of signed samples. One sample transfer is
// taken per clock while s_ready is high; each accepted sample updates a row of
// WINDOW_MAX candidate cells that form a non-increasing queue, and the result of
// a transfer is offered on the m_ channel from the next cycle on. A sample with
// s_first set starts a new stream, and the first len-1 samples of a stream give
// no result, where len is window_len clamped to 1..WINDOW_MAX. The sample leaving
// the window is prefetched from a history memory, so after reset and after
// every write of window_len the input stays not ready while that read settles.
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [swm_pkg::WINDOW_LEN_W-1:0]       cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         s_sample,
    input  logic                                   s_first,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         m_window_max
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EXT_W = (WINDOW_LEN_W > CNT_W) ? WINDOW_LEN_W : CNT_W;
    localparam int IDX_W = CNT_W + 1;

    logic [WINDOW_LEN_W-1:0] window_len_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic [CNT_W-1:0]        fill_base;
    logic                    rd_ok_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    logic [EXT_W-1:0]        len_ext;
    logic [CNT_W-1:0]        len;
    logic [IDX_W-1:0]        rd_idx;
    logic [PTR_W-1:0]        rd_addr;
    logic [SAMPLE_WIDTH-1:0] hist_rdata;

    logic      accept;
    swm_ctrl_t ctrl;

    logic                           cell_valid [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
    logic                           cell_keep  [WINDOW_MAX];

    always_comb begin
        len_ext = EXT_W'(window_len_reg);
        if (len_ext == '0) begin
            len = CNT_W'(1);
        end else if (len_ext > EXT_W'(WINDOW_MAX)) begin
            len = CNT_W'(WINDOW_MAX);
        end else begin
            len = CNT_W'(len_ext);
        end
    end

    assign s_ready = rd_ok_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        fill_base = s_first ? '0 : fill_reg;
        fill_next = (fill_base < len) ? fill_base + CNT_W'(1) : fill_base;

        ctrl.accept = accept;
        ctrl.first  = s_first;
        ctrl.retire = !s_first && (fill_reg >= len) && cell_valid[0]
                      && (cell_value[0] == $signed(hist_rdata));
        ctrl.full   = cell_keep[WINDOW_MAX-1];

        if (!accept) begin
            ptr_next = ptr_reg;
        end else if (ptr_reg == PTR_W'(WINDOW_MAX - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + PTR_W'(1);
        end

        if (IDX_W'(ptr_next) >= IDX_W'(len)) begin
            rd_idx = IDX_W'(ptr_next) - IDX_W'(len);
        end else begin
            rd_idx = IDX_W'(ptr_next) + IDX_W'(WINDOW_MAX) - IDX_W'(len);
        end
        rd_addr = rd_idx[PTR_W-1:0];

        if (accept) begin
            m_valid_next = (fill_next >= len);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_len_reg <= cfg_wr_data;
            end
            ptr_reg     <= ptr_next;
            rd_ok_reg   <= !cfg_wr_en;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                fill_reg <= fill_next;
            end
        end
    end

    swm_history #(
        .DEPTH      (WINDOW_MAX),
        .DATA_WIDTH (SAMPLE_WIDTH),
        .ADDR_W     (PTR_W)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (ptr_reg),
        .wr_data (s_sample),
        .rd_addr (rd_addr),
        .rd_data (hist_rdata)
    );

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic                           prev_keep;
        logic                           next_valid;
        logic signed [SAMPLE_WIDTH-1:0] next_value;

        if (i == 0) begin : g_head
            assign prev_keep = 1'b1;
        end else begin : g_body
            assign prev_keep = cell_keep[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = s_sample;
        end else begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_value = cell_value[i+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sample     (s_sample),
            .prev_keep  (prev_keep),
            .next_valid (next_valid),
            .next_value (next_value),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .keep       (cell_keep[i])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_window_max = cell_value[0];

endmodule
